FILE: rtl/pert_pkg.sv
// ----------------------------------------------------------------------------
// pert_pkg - shared types and constants
// Entry, key, compare and result types plus op, kind and register codes
// for the pending event ack and retry tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pert_pkg;

  // input op codes
  localparam logic [1:0] OP_EVENT = 2'd0;
  localparam logic [1:0] OP_ACK   = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // result kind codes
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_SENT   = 2'd1;
  localparam logic [1:0] KIND_FAIL   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_PROCESS_ID  = 2'd0;
  localparam logic [1:0] CFG_STALL_LIMIT = 2'd1;
  localparam logic [1:0] CFG_RETRY_AGE   = 2'd2;

  localparam logic [15:0] STALL_LIMIT_RST = 16'd64;
  localparam logic [7:0]  RETRY_AGE_RST   = 8'd29;

  // send attempts per tick
  localparam int          NRES_W      = 6;
  localparam logic [5:0]  MAX_RESULTS = 6'd32;

  localparam int SLOT_W = 5;
  localparam int PEND_W = 6;

  typedef struct packed {
    logic [15:0] proc;
    logic [31:0] sent_time;
    logic [31:0] event_id;
    logic [31:0] rx_time;
    logic [31:0] random;
  } entry_t;

  typedef struct packed {
    logic [15:0] proc;
    logic [31:0] event_id;
    logic [31:0] rx_time;
    logic [31:0] random;
  } ack_key_t;

  typedef struct packed {
    logic key_eq;
    logic is_old;
  } cmp_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       key_random;
    logic [31:0]       key_rx_time;
    logic [31:0]       key_event_id;
    logic              ack_found;
    logic              table_full;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/pert_cmp.sv
// ----------------------------------------------------------------------------
// pert_cmp - shared compare unit
// Key match against an acknowledgement and send-age test of one entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pert_cmp (
  input  wire pert_pkg::entry_t   entry,
  input  wire pert_pkg::ack_key_t key,
  input  wire [31:0]              oldest,
  output pert_pkg::cmp_t          result
);

  assign result.key_eq = (entry.random == key.random) &&
                         (entry.rx_time == key.rx_time) &&
                         (entry.event_id == key.event_id) &&
                         (entry.proc == key.proc);
  assign result.is_old = (entry.sent_time < oldest);

endmodule

`default_nettype wire

FILE: rtl/pert_mem.sv
// ----------------------------------------------------------------------------
// pert_mem - entry table
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pert_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire                   clk,
  input  wire                   we,
  input  wire [AW-1:0]          waddr,
  input  wire pert_pkg::entry_t wdata,
  input  wire                   re,
  input  wire [AW-1:0]          raddr,
  output pert_pkg::entry_t      rdata
);

  pert_pkg::entry_t mem [DEPTH];
  pert_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: rtl/pending_event_ack_retry_tracker_unit.sv
// ----------------------------------------------------------------------------
// pending_event_ack_retry_tracker_unit - ack and retry table for sent events
// Keeps sent events until acknowledged, frees slots on matching acks and
// resends entries older than the retry age on a tick.
// ----------------------------------------------------------------------------
// sequence: a new event or status op passes S_DISPATCH and S_FLUSH (one result)
// ack: S_CHK scans slots until a match, S_MOVE refills a freed slot, then S_FLUSH
// tick: S_CHK scans one slot per cycle (pending_count at most) unless a result
//   waits on the output; in_tready stays low from the accept until the last
//   result of the word is queued
// reset (synchronous, rst_n low): table empty, event id 0, registers at defaults
`timescale 1ns / 1ps
`default_nettype none

module pending_event_ack_retry_tracker_unit #(
  parameter int DEPTH = 32
) (
  input  wire          clk,
  input  wire          rst_n,
  // input channel
  input  wire          in_tvalid,
  output logic         in_tready,
  // now_seconds[31:0] random_value[63:32] ack_random[95:64]
  // ack_rx_time[127:96] ack_event_id[159:128] ack_process_id[175:160]
  // ack_size_ok[176] link_ok[177] upstream_length[193:178] zero[199:194]
  input  wire [199:0]  in_tdata,
  // op[1:0]
  input  wire [1:0]    in_tuser,
  // result channel
  output logic         out_tvalid,
  input  wire          out_tready,
  // slot[4:0] key_random[36:5] key_rx_time[68:37] key_event_id[100:69]
  // ack_found[101] table_full[102] stalled[103] pending_now[109:104]
  // zero[111:110]
  output logic [111:0] out_tdata,
  // kind[1:0]
  output logic [1:0]   out_tuser,
  output logic         out_tlast,
  // configuration
  input  wire          cfg_we,
  input  wire [1:0]    cfg_index,
  input  wire [15:0]   cfg_wdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_CHK,
    S_MOVE,
    S_FLUSH
  } state_t;

  // configuration registers
  logic [15:0] proc_id_r;
  logic [15:0] stall_limit_r;
  logic [7:0]  retry_age_r;

  // control state
  state_t                    state_r, state_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic [31:0]               counter_r, counter_nxt;
  logic [AW-1:0]             idx_r, idx_nxt;
  logic [pert_pkg::NRES_W-1:0] n_r, n_nxt;
  pert_pkg::res_t            held_r, held_nxt;

  // latched input word
  logic [1:0]         op_r;
  logic [31:0]        now_r;
  logic [31:0]        rnd_r;
  pert_pkg::ack_key_t ack_r;
  logic               size_ok_r;
  logic               link_r;
  logic [15:0]        upstream_r;
  logic [31:0]        oldest_r;

  // output register
  logic                      out_tvalid_r;
  pert_pkg::res_t            out_res_r;
  logic                      out_stalled_r;
  logic [pert_pkg::PEND_W-1:0] out_pend_r;
  logic                      out_last_r;

  // table access
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  pert_pkg::entry_t mem_wdata, rd_entry;
  pert_pkg::cmp_t   cmp;

  logic          in_accept;
  logic          out_free;
  logic          out_load, out_last_val;
  logic [CW-1:0] last_idx;
  logic          at_end;
  logic [31:0]   in_now;
  logic [31:0]   oldest_calc;
  logic          stall_calc;
  pert_pkg::entry_t entry_new, entry_resent;
  pert_pkg::res_t   res_entry;

  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign last_idx  = count_r - 1'b1;
  assign at_end    = (CW'(idx_r) == last_idx);
  assign in_now    = in_tdata[31:0];

  // resend threshold, zero while now does not exceed the age
  assign oldest_calc = (in_now > {24'd0, retry_age_r}) ?
                       (in_now - {24'd0, retry_age_r}) : 32'd0;

  assign stall_calc = (({1'b0, upstream_r} + 17'(count_r)) >= {1'b0, stall_limit_r});

  // entry written by a new event
  always_comb begin
    entry_new.proc      = proc_id_r;
    entry_new.sent_time = now_r;
    entry_new.event_id  = counter_r;
    entry_new.rx_time   = now_r;
    entry_new.random    = rnd_r;
  end

  // entry rewritten by a resend, same key with a fresh send time
  always_comb begin
    entry_resent           = rd_entry;
    entry_resent.sent_time = now_r;
  end

  // result word for the entry under the scan pointer
  always_comb begin
    res_entry.kind          = link_r ? pert_pkg::KIND_SENT : pert_pkg::KIND_FAIL;
    res_entry.slot          = pert_pkg::SLOT_W'(idx_r);
    res_entry.key_random    = rd_entry.random;
    res_entry.key_rx_time   = rd_entry.rx_time;
    res_entry.key_event_id  = rd_entry.event_id;
    res_entry.ack_found     = 1'b0;
    res_entry.table_full    = 1'b0;
  end

  pert_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_entry)
  );

  pert_cmp u_cmp (
    .entry  (rd_entry),
    .key    (ack_r),
    .oldest (oldest_r),
    .result (cmp)
  );

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    counter_nxt  = counter_r;
    idx_nxt      = idx_r;
    n_nxt        = n_r;
    held_nxt     = held_r;
    mem_we       = 1'b0;
    mem_waddr    = idx_r;
    mem_wdata    = entry_resent;
    mem_re       = 1'b0;
    mem_raddr    = idx_r + 1'b1;
    out_load     = 1'b0;
    out_last_val = 1'b0;
    in_tready    = (state_r == S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        held_nxt      = '0;
        held_nxt.kind = pert_pkg::KIND_STATUS;
        state_nxt     = S_FLUSH;
        case (op_r)
          pert_pkg::OP_EVENT: begin
            if (count_r == FULL_CNT) begin
              held_nxt.table_full = 1'b1;
            end else begin
              mem_we                 = 1'b1;
              mem_waddr              = count_r[AW-1:0];
              mem_wdata              = entry_new;
              held_nxt.kind          = link_r ? pert_pkg::KIND_SENT : pert_pkg::KIND_FAIL;
              held_nxt.slot          = pert_pkg::SLOT_W'(count_r);
              held_nxt.key_random    = rnd_r;
              held_nxt.key_rx_time   = now_r;
              held_nxt.key_event_id  = counter_r;
              counter_nxt            = counter_r + 32'd1;
              count_nxt              = count_r + 1'b1;
            end
          end
          pert_pkg::OP_ACK: begin
            if (size_ok_r && count_r != '0) begin
              mem_re    = 1'b1;
              mem_raddr = '0;
              idx_nxt   = '0;
              state_nxt = S_CHK;
            end
          end
          pert_pkg::OP_TICK: begin
            if (count_r != '0) begin
              mem_re    = 1'b1;
              mem_raddr = '0;
              idx_nxt   = '0;
              n_nxt     = '0;
              state_nxt = S_CHK;
            end
          end
          default: begin
          end
        endcase
      end

      S_CHK: begin
        if (op_r == pert_pkg::OP_ACK) begin
          if (cmp.key_eq) begin
            held_nxt.ack_found = 1'b1;
            if (at_end) begin
              count_nxt = last_idx;
              state_nxt = S_FLUSH;
            end else begin
              // fetch the last entry to fill the freed slot
              mem_re    = 1'b1;
              mem_raddr = last_idx[AW-1:0];
              state_nxt = S_MOVE;
            end
          end else if (at_end) begin
            state_nxt = S_FLUSH;
          end else begin
            mem_re  = 1'b1;
            idx_nxt = idx_r + 1'b1;
          end
        end else begin
          if (cmp.is_old) begin
            // a held result is pushed out before the new one takes its place
            if (n_r == '0 || out_free) begin
              out_load  = (n_r != '0);
              mem_we    = 1'b1;
              held_nxt  = res_entry;
              n_nxt     = n_r + 1'b1;
              if (!link_r || at_end || n_r == (pert_pkg::MAX_RESULTS - 1'b1)) begin
                state_nxt = S_FLUSH;
              end else begin
                mem_re  = 1'b1;
                idx_nxt = idx_r + 1'b1;
              end
            end
          end else if (at_end) begin
            state_nxt = S_FLUSH;
          end else begin
            mem_re  = 1'b1;
            idx_nxt = idx_r + 1'b1;
          end
        end
      end

      S_MOVE: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = rd_entry;
        count_nxt = last_idx;
        state_nxt = S_FLUSH;
      end

      S_FLUSH: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_last_val = 1'b1;
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      count_r       <= '0;
      counter_r     <= '0;
      idx_r         <= '0;
      n_r           <= '0;
      out_tvalid_r  <= 1'b0;
      proc_id_r     <= '0;
      stall_limit_r <= pert_pkg::STALL_LIMIT_RST;
      retry_age_r   <= pert_pkg::RETRY_AGE_RST;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      counter_r <= counter_nxt;
      idx_r     <= idx_nxt;
      n_r       <= n_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          pert_pkg::CFG_PROCESS_ID:  proc_id_r     <= cfg_wdata;
          pert_pkg::CFG_STALL_LIMIT: stall_limit_r <= cfg_wdata;
          pert_pkg::CFG_RETRY_AGE:   retry_age_r   <= cfg_wdata[7:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    held_r <= held_nxt;
    if (in_accept) begin
      op_r           <= in_tuser;
      now_r          <= in_now;
      rnd_r          <= in_tdata[63:32];
      ack_r.random    <= in_tdata[95:64];
      ack_r.rx_time   <= in_tdata[127:96];
      ack_r.event_id  <= in_tdata[159:128];
      ack_r.proc      <= in_tdata[175:160];
      size_ok_r      <= in_tdata[176];
      link_r         <= in_tdata[177];
      upstream_r     <= in_tdata[193:178];
      oldest_r       <= oldest_calc;
    end
    if (out_load) begin
      out_res_r     <= held_r;
      out_stalled_r <= stall_calc;
      out_pend_r    <= pert_pkg::PEND_W'(count_r);
      out_last_r    <= out_last_val;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_pend_r, out_stalled_r, out_res_r.table_full,
                       out_res_r.ack_found, out_res_r.key_event_id,
                       out_res_r.key_rx_time, out_res_r.key_random,
                       out_res_r.slot};

endmodule

`default_nettype wire
